// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
    `ASSERT_AT(lbl, clk_s, rst_s, !(expr), msg)
`else
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg)
`endif

`endif

// File: src/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Types, codes and character class functions of the source token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int unsigned NUM_SLOTS = 3;

    // result kinds
    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // token types
    localparam logic [2:0] TT_PUNCT  = 3'd0;
    localparam logic [2:0] TT_OPER   = 3'd1;
    localparam logic [2:0] TT_SYMBOL = 3'd2;
    localparam logic [2:0] TT_STRING = 3'd3;
    localparam logic [2:0] TT_INT    = 3'd4;
    localparam logic [2:0] TT_FLOAT  = 3'd5;
    localparam logic [2:0] TT_EOF    = 3'd6;

    // number base codes
    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    localparam logic [4:0] NO_DIGIT = 5'd16;

    // characters with a role of their own
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_X      = 8'h78;

    // operator buffer codes
    localparam logic [15:0] OPS_DOTDOT = 16'h2E2E;
    localparam logic [15:0] OPS_FULL   = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [7:0]  value_byte;
        logic [2:0]  token_type;
        logic [63:0] int_value;
        logic        conv_error;
        logic        last;
    } stl_res_t;

    typedef struct packed {
        stl_res_t [NUM_SLOTS-1:0] res;
        logic [1:0]               count;
    } stl_batch_t;

    typedef struct packed {
        logic room;
        logic one_left;
    } stl_qstat_t;

    function automatic stl_res_t mk_value(input logic [7:0] c);
        stl_res_t r;
        begin
            r            = '0;
            r.kind       = KIND_VALUE;
            r.value_byte = c;
            return r;
        end
    endfunction

    function automatic stl_res_t mk_end(input logic [2:0] tt, input logic [63:0] iv,
                                        input logic err);
        stl_res_t r;
        begin
            r            = '0;
            r.kind       = KIND_END;
            r.token_type = tt;
            r.int_value  = iv;
            r.conv_error = err;
            return r;
        end
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        logic p;
        begin
            case (c) inside
                "(", ")", "{", "}", "[", "]", ":", ",", ";", "?": p = 1'b1;
                default: p = 1'b0;
            endcase
            return p;
        end
    endfunction

    function automatic logic op_start(input logic [7:0] c);
        logic p;
        begin
            case (c) inside
                ".", "+", "-", "*", "/", "%", "&", "|", "^", "=", "<", ">", "!", "~":
                    p = 1'b1;
                default: p = 1'b0;
            endcase
            return p;
        end
    endfunction

    function automatic logic op_extends(input logic [15:0] ops, input logic [7:0] c);
        logic e;
        begin
            e = 1'b0;
            if (ops == OPS_DOTDOT) begin
                e = (c == CH_DOT);
            end else if (ops[15:8] == 8'h00) begin
                case (ops[7:0]) inside
                    "+": e = (c == "=") || (c == "+");
                    "-": e = (c == "=") || (c == "-") || (c == ">");
                    "=": e = (c == "=") || (c == ">");
                    "<": e = (c == "=") || (c == "<");
                    ">": e = (c == "=") || (c == ">");
                    ".": e = (c == CH_DOT);
                    "*", "/", "%", "&", "|", "^", "!", "~": e = (c == "=");
                    default: e = 1'b0;
                endcase
            end
            return e;
        end
    endfunction

    function automatic logic [7:0] decode_escape(input logic [7:0] c);
        logic [7:0] d;
        begin
            case (c)
                "a":     d = 8'd7;
                "b":     d = 8'd8;
                "f":     d = 8'd12;
                "n":     d = 8'd10;
                "r":     d = 8'd13;
                "t":     d = 8'd9;
                "v":     d = 8'd11;
                default: d = c;
            endcase
            return d;
        end
    endfunction

    // digit value in the given base, NO_DIGIT when the byte is not one
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] code);
        logic [4:0] d;
        begin
            d = NO_DIGIT;
            if (is_dec(c)) begin
                d = 5'(c - 8'h30);
            end else if ((c >= "a") && (c <= "f")) begin
                d = 5'(c - 8'h57);
            end else if ((c >= "A") && (c <= "F")) begin
                d = 5'(c - 8'h37);
            end
            if ((code == BASE_BIN) && (d > 5'd1)) d = NO_DIGIT;
            if ((code == BASE_OCT) && (d > 5'd7)) d = NO_DIGIT;
            if ((code == BASE_DEC) && (d > 5'd9)) d = NO_DIGIT;
            return d;
        end
    endfunction

endpackage

// File: src/stl_core.sv
// ----------------------------------------------------------------------------
// stl_core
// Lexer state and the combinational step that turns one byte into its results.
// ----------------------------------------------------------------------------
module stl_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         in_byte,
    input  logic               end_of_input,
    output stl_pkg::stl_batch_t batch
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_CMT  = 3'd1;
    localparam logic [2:0] M_SYM  = 3'd2;
    localparam logic [2:0] M_STR  = 3'd3;
    localparam logic [2:0] M_CHR  = 3'd4;
    localparam logic [2:0] M_NUM  = 3'd5;
    localparam logic [2:0] M_OPR  = 3'd6;

    logic [2:0]  mode_reg,  mode_next;
    logic        esc_reg,   esc_next;
    logic        az_reg,    az_next;
    logic [1:0]  base_reg,  base_next;
    logic        pt_reg,    pt_next;
    logic [63:0] acc_reg,   acc_next;
    logic        dseen_reg, dseen_next;
    logic        sat_reg,   sat_next;
    logic [8:0]  fc_reg,    fc_next;
    logic [15:0] ops_reg,   ops_next;

    stl_pkg::stl_res_t [stl_pkg::NUM_SLOTS-1:0] res;
    logic [1:0]  n_cnt;
    logic        rexam;
    logic        skip;
    logic [4:0]  dig;
    logic [67:0] scaled;
    logic [67:0] sum;
    stl_pkg::stl_res_t num_end;

    always_comb
    begin
        dig = stl_pkg::digit_of(in_byte, base_reg);
        case (base_reg)
            stl_pkg::BASE_BIN: scaled = {4'b0, acc_reg} << 1;
            stl_pkg::BASE_OCT: scaled = {4'b0, acc_reg} << 3;
            stl_pkg::BASE_DEC: scaled = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1);
            default:           scaled = {4'b0, acc_reg} << 4;
        endcase
        sum = scaled + 68'(dig);
        if (pt_reg) begin
            num_end = stl_pkg::mk_end(stl_pkg::TT_FLOAT, 64'd0, 1'b0);
        end else begin
            num_end = stl_pkg::mk_end(stl_pkg::TT_INT, acc_reg, !dseen_reg || sat_reg);
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        az_next    = az_reg;
        base_next  = base_reg;
        pt_next    = pt_reg;
        acc_next   = acc_reg;
        dseen_next = dseen_reg;
        sat_next   = sat_reg;
        fc_next    = fc_reg;
        ops_next   = ops_reg;
        res        = '0;
        n_cnt      = 2'd0;
        rexam      = 1'b0;
        skip       = 1'b0;

        if (end_of_input) begin
            // close any pending token, then eof and back to the reset state
            case (mode_reg)
                M_SYM:
                begin
                    res[n_cnt] = stl_pkg::mk_end(stl_pkg::TT_SYMBOL, 64'd0, 1'b0);
                    n_cnt = n_cnt + 2'd1;
                end
                M_STR:
                begin
                    res[n_cnt] = stl_pkg::mk_end(stl_pkg::TT_STRING, 64'd0, 1'b0);
                    n_cnt = n_cnt + 2'd1;
                end
                M_CHR:
                begin
                    res[n_cnt] = stl_pkg::mk_end(stl_pkg::TT_INT, {56'd0, fc_reg[7:0]},
                                                 !fc_reg[8]);
                    n_cnt = n_cnt + 2'd1;
                end
                M_NUM:
                begin
                    res[n_cnt] = num_end;
                    n_cnt = n_cnt + 2'd1;
                end
                M_OPR:
                begin
                    res[n_cnt] = stl_pkg::mk_end(stl_pkg::TT_OPER, 64'd0, 1'b0);
                    n_cnt = n_cnt + 2'd1;
                end
                default: ;
            endcase
            res[n_cnt] = stl_pkg::mk_end(stl_pkg::TT_EOF, 64'd0, 1'b0);
            n_cnt = n_cnt + 2'd1;
            mode_next  = M_IDLE;
            esc_next   = 1'b0;
            az_next    = 1'b0;
            base_next  = stl_pkg::BASE_BIN;
            pt_next    = 1'b0;
            acc_next   = '0;
            dseen_next = 1'b0;
            sat_next   = 1'b0;
            fc_next    = '0;
            ops_next   = '0;
        end else begin
            case (mode_reg)
                M_CMT:
                begin
                    if (in_byte == stl_pkg::CH_NL) mode_next = M_IDLE;
                end
                M_SYM:
                begin
                    if (stl_pkg::is_alpha(in_byte) || stl_pkg::is_dec(in_byte) ||
                        (in_byte == stl_pkg::CH_USCORE)) begin
                        res[n_cnt] = stl_pkg::mk_value(in_byte);
                        n_cnt = n_cnt + 2'd1;
                    end else begin
                        res[n_cnt] = stl_pkg::mk_end(stl_pkg::TT_SYMBOL, 64'd0, 1'b0);
                        n_cnt = n_cnt + 2'd1;
                        rexam = 1'b1;
                    end
                end
                M_STR:
                begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        res[n_cnt] = stl_pkg::mk_value(stl_pkg::decode_escape(in_byte));
                        n_cnt = n_cnt + 2'd1;
                    end else if (in_byte == stl_pkg::CH_BSLASH) begin
                        esc_next = 1'b1;
                    end else if (in_byte == stl_pkg::CH_DQUOTE) begin
                        res[n_cnt] = stl_pkg::mk_end(stl_pkg::TT_STRING, 64'd0, 1'b0);
                        n_cnt = n_cnt + 2'd1;
                        mode_next = M_IDLE;
                    end else begin
                        res[n_cnt] = stl_pkg::mk_value(in_byte);
                        n_cnt = n_cnt + 2'd1;
                    end
                end
                M_CHR:
                begin
                    // keep only the first decoded character
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        if (!fc_reg[8]) fc_next = {1'b1, stl_pkg::decode_escape(in_byte)};
                    end else if (in_byte == stl_pkg::CH_BSLASH) begin
                        esc_next = 1'b1;
                    end else if (in_byte == stl_pkg::CH_SQUOTE) begin
                        res[n_cnt] = stl_pkg::mk_end(stl_pkg::TT_INT, {56'd0, fc_reg[7:0]},
                                                     !fc_reg[8]);
                        n_cnt = n_cnt + 2'd1;
                        mode_next = M_IDLE;
                        fc_next = '0;
                    end else begin
                        if (!fc_reg[8]) fc_next = {1'b1, in_byte};
                    end
                end
                M_NUM:
                begin
                    if (az_reg) begin
                        az_next = 1'b0;
                        if ((in_byte == stl_pkg::CH_B) || (in_byte == stl_pkg::CH_X)) begin
                            base_next  = (in_byte == stl_pkg::CH_B) ? stl_pkg::BASE_BIN
                                                                     : stl_pkg::BASE_HEX;
                            dseen_next = 1'b0;
                            skip       = 1'b1;
                        end
                    end
                    if (!skip) begin
                        if ((base_reg == stl_pkg::BASE_DEC) && !pt_reg &&
                            (in_byte == stl_pkg::CH_DOT)) begin
                            pt_next = 1'b1;
                        end else if (dig != stl_pkg::NO_DIGIT) begin
                            // saturate to all ones on overflow
                            if (|sum[67:64]) begin
                                acc_next = '1;
                                sat_next = 1'b1;
                            end else begin
                                acc_next = sum[63:0];
                            end
                            dseen_next = 1'b1;
                        end else begin
                            res[n_cnt] = num_end;
                            n_cnt = n_cnt + 2'd1;
                            rexam = 1'b1;
                        end
                    end
                end
                M_OPR:
                begin
                    if (stl_pkg::op_extends(ops_reg, in_byte)) begin
                        res[n_cnt] = stl_pkg::mk_value(in_byte);
                        n_cnt = n_cnt + 2'd1;
                        if (ops_reg[15:8] != 8'h00) begin
                            ops_next = stl_pkg::OPS_FULL;
                        end else begin
                            ops_next = {ops_reg[7:0], in_byte};
                        end
                    end else begin
                        res[n_cnt] = stl_pkg::mk_end(stl_pkg::TT_OPER, 64'd0, 1'b0);
                        n_cnt = n_cnt + 2'd1;
                        ops_next = '0;
                        rexam = 1'b1;
                    end
                end
                default: rexam = 1'b1;
            endcase

            // examine the byte again as the start of a new token
            if (rexam) begin
                mode_next = M_IDLE;
                if (in_byte == stl_pkg::CH_HASH) begin
                    mode_next = M_CMT;
                end else if (stl_pkg::is_punct(in_byte)) begin
                    res[n_cnt] = stl_pkg::mk_value(in_byte);
                    n_cnt = n_cnt + 2'd1;
                    res[n_cnt] = stl_pkg::mk_end(stl_pkg::TT_PUNCT, 64'd0, 1'b0);
                    n_cnt = n_cnt + 2'd1;
                end else if (in_byte == stl_pkg::CH_DQUOTE) begin
                    mode_next = M_STR;
                    esc_next  = 1'b0;
                end else if (in_byte == stl_pkg::CH_SQUOTE) begin
                    mode_next = M_CHR;
                    esc_next  = 1'b0;
                    fc_next   = '0;
                end else if (stl_pkg::op_start(in_byte)) begin
                    res[n_cnt] = stl_pkg::mk_value(in_byte);
                    n_cnt = n_cnt + 2'd1;
                    ops_next  = {8'h00, in_byte};
                    mode_next = M_OPR;
                end else if (stl_pkg::is_dec(in_byte)) begin
                    mode_next  = M_NUM;
                    pt_next    = 1'b0;
                    sat_next   = 1'b0;
                    dseen_next = 1'b1;
                    if (in_byte == stl_pkg::CH_ZERO) begin
                        az_next   = 1'b1;
                        base_next = stl_pkg::BASE_OCT;
                        acc_next  = '0;
                    end else begin
                        az_next   = 1'b0;
                        base_next = stl_pkg::BASE_DEC;
                        acc_next  = {60'd0, 4'(in_byte - stl_pkg::CH_ZERO)};
                    end
                end else if (stl_pkg::is_alpha(in_byte) || (in_byte == stl_pkg::CH_USCORE)) begin
                    res[n_cnt] = stl_pkg::mk_value(in_byte);
                    n_cnt = n_cnt + 2'd1;
                    mode_next = M_SYM;
                end
            end
        end

        for (int i = 0; i < stl_pkg::NUM_SLOTS; i++) begin
            res[i].last = (n_cnt != 2'd0) && (2'(i) == (n_cnt - 2'd1));
        end
        batch.res   = res;
        batch.count = n_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_IDLE;
            esc_reg   <= 1'b0;
            az_reg    <= 1'b0;
            base_reg  <= stl_pkg::BASE_BIN;
            pt_reg    <= 1'b0;
            acc_reg   <= '0;
            dseen_reg <= 1'b0;
            sat_reg   <= 1'b0;
            fc_reg    <= '0;
            ops_reg   <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            esc_reg   <= esc_next;
            az_reg    <= az_next;
            base_reg  <= base_next;
            pt_reg    <= pt_next;
            acc_reg   <= acc_next;
            dseen_reg <= dseen_next;
            sat_reg   <= sat_next;
            fc_reg    <= fc_next;
            ops_reg   <= ops_next;
        end
    end

endmodule

// File: src/stl_outq.sv
// ----------------------------------------------------------------------------
// stl_outq
// Result register: holds the results of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module stl_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  stl_pkg::stl_batch_t batch,
    input  logic                take,
    output logic                valid,
    output stl_pkg::stl_res_t   head,
    output stl_pkg::stl_qstat_t stat
);

    stl_pkg::stl_res_t slot_reg [stl_pkg::NUM_SLOTS];
    logic [1:0] head_reg, head_next;
    logic [1:0] rem_reg,  rem_next;

    assign valid         = (rem_reg != 2'd0);
    assign head          = slot_reg[head_reg];
    // room when empty, or once the final result of the held byte is being transferred
    assign stat.room     = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && take);
    assign stat.one_left = (rem_reg == 2'd1);

    always_comb
    begin
        head_next = head_reg;
        rem_next  = rem_reg;
        if (load) begin
            head_next = 2'd0;
            rem_next  = batch.count;
        end else if (take) begin
            head_next = head_reg + 2'd1;
            rem_next  = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg <= 2'd0;
            rem_reg  <= 2'd0;
        end else begin
            head_reg <= head_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            for (int i = 0; i < stl_pkg::NUM_SLOTS; i++) begin
                slot_reg[i] <= batch.res[i];
            end
        end
    end

endmodule

// File: src/source_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// source_token_lexer_unit
// Streaming lexer: one source byte in, up to three value/token-end results out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  byte      in         byte_valid / byte_stall    in_byte, end_of_input
//  result    out        result_valid / result_stall kind, value_byte, token_type,
//                                                  int_value, conv_error, last
//
//  A byte waits in the input register until the result register has room; one
//  step then updates the lexer state and fills the result register. A byte with
//  k results (k is 0 to 3) holds the result port until all are taken; bytes with
//  at most one result flow at one per cycle unless result_stall is high. The
//  single result port sets the rate. Reset clears the lexer to idle and empties
//  both registers. With the result side stalled, one more byte is still taken
//  into the input register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module source_token_lexer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        kind,
    output logic [7:0]  value_byte,
    output logic [2:0]  token_type,
    output logic [63:0] int_value,
    output logic        conv_error,
    output logic        last
);

    logic                in_vld_reg;
    logic [7:0]          in_byte_reg;
    logic                in_eoi_reg;
    logic                consume;
    logic                take;
    stl_pkg::stl_batch_t batch;
    stl_pkg::stl_res_t   head;
    stl_pkg::stl_qstat_t qstat;

    assign take       = result_valid && !result_stall;
    assign consume    = in_vld_reg && qstat.room;
    assign byte_stall = in_vld_reg && !qstat.room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (byte_valid && !byte_stall) begin
            in_vld_reg <= 1'b1;
        end else if (consume) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall) begin
            in_byte_reg <= in_byte;
            in_eoi_reg  <= end_of_input;
        end
    end

    stl_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (consume),
        .in_byte      (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .batch        (batch)
    );

    stl_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (consume),
        .batch (batch),
        .take  (take),
        .valid (result_valid),
        .head  (head),
        .stat  (qstat)
    );

    assign kind       = head.kind;
    assign value_byte = head.value_byte;
    assign token_type = head.token_type;
    assign int_value  = head.int_value;
    assign conv_error = head.conv_error;
    assign last       = head.last;

    `ASSERT_AT(a_last_marks_final, clk, rst_n, result_valid |-> (last == qstat.one_left), "last flag out of step with held results")
    `ASSERT_AT(a_eof_is_last, clk, rst_n, (result_valid && kind && (token_type == stl_pkg::TT_EOF)) |-> last, "eof result not marked last")
    `ASSERT_NEVER(a_value_clean, clk, rst_n, result_valid && !kind && ((token_type != stl_pkg::TT_PUNCT) || (int_value != 64'd0) || conv_error), "value byte carries token fields")
    `ASSERT_AT(a_eoi_gives_result, clk, rst_n, (consume && in_eoi_reg) |=> result_valid, "end of input produced no result")

endmodule
